// ===== sv/sobel_edge_magnitude_rgb_assert.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
// No dependencies; include inside a module that has clk and rst_n.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

// Condition must never hold outside reset.
`define SEM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/sem_pkg.sv =====
// Shared types, constants and the Sobel gradient function.
// No dependencies.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 4096;
  localparam int unsigned WidthRegW    = 11;
  localparam int unsigned HeightRegW   = 13;
  localparam int unsigned CfgDataW     = 13;
  localparam logic [10:0] WidthReset   = 11'd1024;
  localparam logic [12:0] HeightReset  = 13'd1024;
  localparam int unsigned QueueDepth   = 2;
  localparam logic [20:0] SatLimit     = 21'd65280;
  localparam logic [7:0]  EdgeMax      = 8'd255;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // [0] red, [1] green, [2] blue
  typedef logic [2:0][7:0] pix_t;

  typedef struct packed {
    pix_t mid;
    pix_t up;
  } lines_t;

  typedef struct packed {
    logic signed [10:0] gx;
    logic signed [10:0] gy;
  } grad_t;

  typedef struct packed {
    grad_t [2:0] g;
    logic        last;
  } grad_item_t;

  // p[r*3+c]: 3x3 neighborhood of one channel
  function automatic grad_t sobel_grad(input logic [8:0][7:0] p);
    logic signed [11:0] pos_x;
    logic signed [11:0] neg_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] neg_y;
    grad_t g;
    pos_x = $signed({4'b0, p[2]}) + $signed({3'b0, p[5], 1'b0}) + $signed({4'b0, p[8]});
    neg_x = $signed({4'b0, p[0]}) + $signed({3'b0, p[3], 1'b0}) + $signed({4'b0, p[6]});
    pos_y = $signed({4'b0, p[6]}) + $signed({3'b0, p[7], 1'b0}) + $signed({4'b0, p[8]});
    neg_y = $signed({4'b0, p[0]}) + $signed({3'b0, p[1], 1'b0}) + $signed({4'b0, p[2]});
    g.gx = 11'(pos_x - neg_x);
    g.gy = 11'(pos_y - neg_y);
    return g;
  endfunction

endpackage

// ===== sv/sobel_edge_magnitude_rgb.sv =====
// Sobel 3x3 edge magnitude over an RGB raster stream, per channel, saturated at 255.
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
//
// Send pixels in raster order, then image_width+1 flush items (tuser high) per frame;
// the result for a pixel leaves once the input has moved width+1 items past it, and
// tlast marks the frame's last result. Neighbors outside the image read as black.
// The front end takes an item while idle (line store read), then does the write-back and
// gradient sums before taking the next, holds off while the queue is full, and pushes
// gradients into a two-entry queue. The back end handles one result at a time: squaring
// as it pops an item, eight binary-search steps of the rounded root on an 8x8 multiplier
// per channel, and loading the output register once it is free; it takes no new item
// until then. Line stores need no clearing after reset: stale rows are always masked.
// Write image_width/image_height only while the block is idle; a write restarts the frame.
`timescale 1ns / 1ps
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DefMaxHeight
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [23:0]                   in_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                          in_tuser,   // kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // edge_red, edge_green, edge_blue
  output logic                          out_tlast,  // last_pixel
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_wdata
);
  sem_pkg::grad_item_t q_in, q_head;
  logic q_push, q_pop, q_full, q_empty;

  // front: window and gradients
  sem_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  // decouple front and back
  sem_fifo #(
    .DEPTH(sem_pkg::QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: magnitude and output transfer
  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );
endmodule

// ===== sv/sem_fifo.sv =====
// Short queue of gradient items between front and back.
// Depends on sem_pkg and sobel_edge_magnitude_rgb_assert.svh.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_rgb_assert.svh"
module sem_fifo #(
  parameter int unsigned DEPTH = sem_pkg::QueueDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sem_pkg::grad_item_t  push_data,
  input  logic                 pop,
  output sem_pkg::grad_item_t  head,
  output logic                 full,
  output logic                 empty
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  sem_pkg::grad_item_t store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  assign full  = (count_r == CNTW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  `SEM_ASSERT_NEVER(a_no_overflow, push && full && !pop, "push into full queue")
  `SEM_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from empty queue")
  `SEM_ASSERT_IMPL(a_count_bound, 1'b1, 32'(count_r) <= DEPTH, "queue count beyond depth")
endmodule

// ===== sv/sem_front.sv =====
// Front end: accepts pixels, keeps line stores and window, forms Sobel gradients.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_front #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = sem_pkg::DefMaxHeight
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [sem_pkg::CfgDataW-1:0]      cfg_wdata,
  input  logic                              q_full,
  output logic                              q_push,
  output sem_pkg::grad_item_t               q_data
);
  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  typedef enum logic {FS_IDLE, FS_CALC} fstate_t;

  fstate_t                       state_r;
  logic [sem_pkg::WidthRegW-1:0] width_r;
  logic [sem_pkg::HeightRegW-1:0] height_r;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [RW-1:0]                 row_r, row_nxt;
  sem_pkg::pix_t [5:0]           wc_r, wc_nxt;
  sem_pkg::pix_t                 pix_r;
  sem_pkg::lines_t               rd_r;
  sem_pkg::lines_t               line_mem [MAX_WIDTH];

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  sem_pkg::pix_t [2:0] newcol;
  sem_pkg::pix_t [2:0][2:0] nb;   // [row][col]
  logic          col0, emit, last, left_m, right_m, top_m, bot_m;
  logic [RW-1:0] cr;
  logic [8:0][7:0] chan_nb [3];
  logic          accept;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  assign in_tready = (state_r == FS_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;

  // neighborhood of the pixel one row and one column behind the input
  always_comb begin
    newcol[0] = rd_r.up;
    newcol[1] = rd_r.mid;
    newcol[2] = pix_r;
    col0    = (col_r == '0);
    emit    = (row_r >= RW'(2)) || ((row_r == RW'(1)) && !col0);
    cr      = col0 ? row_r - RW'(2) : row_r - RW'(1);
    left_m  = (col_r == CW'(1)) || (col0 && (w_eff == WW'(1)));
    right_m = col0;
    top_m   = col0 ? (row_r == RW'(2)) : (row_r == RW'(1));
    bot_m   = ((RW + 1)'(cr) + 1'b1) >= (RW + 1)'(h_eff);
    last    = col0 && ((RW + 1)'(row_r) == (RW + 1)'(h_eff) + 1'b1);
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = left_m ? '0 : wc_r[r];
      nb[r][1] = wc_r[3 + r];
      nb[r][2] = right_m ? '0 : newcol[r];
    end
    if (top_m) begin
      nb[0] = '0;
    end
    if (bot_m) begin
      nb[2] = '0;
    end
    for (int ch = 0; ch < 3; ch++) begin
      for (int k = 0; k < 9; k++) begin
        chan_nb[ch][k] = nb[k / 3][k % 3][ch];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      q_data.g[ch] = sem_pkg::sobel_grad(chan_nb[ch]);
    end
    q_data.last = last;
    q_push      = (state_r == FS_CALC) && emit;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      wc_nxt[r]     = wc_r[3 + r];
      wc_nxt[3 + r] = newcol[r];
    end
    col_nxt = col_r;
    row_nxt = row_r;
    if (last) begin
      wc_nxt  = '0;
      col_nxt = '0;
      row_nxt = '0;
    end else if (WW'(col_r) + 1'b1 >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FS_IDLE;
      width_r  <= sem_pkg::WidthReset;
      height_r <= sem_pkg::HeightReset;
      col_r    <= '0;
      row_r    <= '0;
      wc_r     <= '0;
    end else if (cfg_we) begin
      // any register write restarts the frame
      if (cfg_index == sem_pkg::REG_WIDTH) begin
        width_r <= cfg_wdata[sem_pkg::WidthRegW-1:0];
      end else begin
        height_r <= cfg_wdata[sem_pkg::HeightRegW-1:0];
      end
      col_r <= '0;
      row_r <= '0;
      wc_r  <= '0;
    end else begin
      unique case (state_r)
        FS_IDLE: begin
          if (accept) begin
            state_r <= FS_CALC;
          end
        end
        FS_CALC: begin
          wc_r    <= wc_nxt;
          col_r   <= col_nxt;
          row_r   <= row_nxt;
          state_r <= FS_IDLE;
        end
        default: state_r <= FS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= ((32'(row_r) < 32'(h_eff)) && !in_tuser) ? sem_pkg::pix_t'(in_tdata) : '0;
      rd_r  <= line_mem[col_r];
    end
    if (state_r == FS_CALC) begin
      line_mem[col_r] <= '{mid: pix_r, up: rd_r.mid};
    end
  end
endmodule

// ===== sv/sem_back.sv =====
// Back end: squares gradients, takes rounded saturated roots, drives results.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sem_pkg::grad_item_t q_head,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [23:0]         out_tdata,
  output logic                out_tlast
);
  typedef enum logic [1:0] {BS_IDLE, BS_ROOT, BS_DONE} bstate_t;

  bstate_t          state_r;
  logic [2:0]       step_r;
  logic [20:0]      sq_r [3];
  logic [7:0]       lo_r [3];
  logic [7:0]       hi_r [3];
  logic             last_r;
  logic             out_valid_r;
  sem_pkg::pix_t    out_data_r;
  logic             out_last_r;

  logic [20:0]      sq_nxt [3];
  logic [7:0]       lo_nxt [3];
  logic [7:0]       hi_nxt [3];
  logic [7:0]       mid [3];
  logic [16:0]      tst [3];
  logic signed [21:0] px [3];
  logic signed [21:0] py [3];
  sem_pkg::pix_t    edge_val;
  logic             out_free;

  assign q_pop      = (state_r == BS_IDLE) && !q_empty;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      px[ch]     = q_head.g[ch].gx * q_head.g[ch].gx;
      py[ch]     = q_head.g[ch].gy * q_head.g[ch].gy;
      sq_nxt[ch] = 21'(px[ch]) + 21'(py[ch]);
      // binary search for the smallest r with r*r + r >= sum
      mid[ch]    = 8'((9'(lo_r[ch]) + 9'(hi_r[ch])) >> 1);
      tst[ch]    = 17'(mid[ch]) * 17'(mid[ch]) + 17'(mid[ch]);
      lo_nxt[ch] = lo_r[ch];
      hi_nxt[ch] = hi_r[ch];
      if (lo_r[ch] < hi_r[ch]) begin
        if (21'(tst[ch]) >= sq_r[ch]) begin
          hi_nxt[ch] = mid[ch];
        end else begin
          lo_nxt[ch] = mid[ch] + 8'd1;
        end
      end
      edge_val[ch] = (sq_r[ch] > sem_pkg::SatLimit) ? sem_pkg::EdgeMax : lo_r[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == BS_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        BS_IDLE: begin
          if (!q_empty) begin
            step_r  <= '0;
            state_r <= BS_ROOT;
          end
        end
        BS_ROOT: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= BS_DONE;
          end
        end
        BS_DONE: begin
          if (out_free) begin
            state_r <= BS_IDLE;
          end
        end
        default: state_r <= BS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int ch = 0; ch < 3; ch++) begin
        sq_r[ch] <= sq_nxt[ch];
        lo_r[ch] <= 8'd0;
        hi_r[ch] <= 8'd255;
      end
      last_r <= q_head.last;
    end else if (state_r == BS_ROOT) begin
      for (int ch = 0; ch < 3; ch++) begin
        lo_r[ch] <= lo_nxt[ch];
        hi_r[ch] <= hi_nxt[ch];
      end
    end
    if ((state_r == BS_DONE) && out_free) begin
      out_data_r <= edge_val;
      out_last_r <= last_r;
    end
  end
endmodule
